// ===== hw/rtl/sicc_pkg.sv =====
// Shared types, constants and functions for the SI section deframer and CRC check.
// No dependencies; every module of the block imports this package.
package sicc_pkg;

   localparam int unsigned BytePosWidth = 13;
   localparam int unsigned LenWidth     = 12;
   localparam int unsigned CrcWidth     = 32;

   localparam logic [CrcWidth-1:0]     CrcPoly          = 32'h04C1_1DB7;
   localparam logic [CrcWidth-1:0]     CrcInit          = 32'hFFFF_FFFF;
   localparam logic [BytePosWidth-1:0] PrefixBytes      = 13'd3;
   localparam logic [LenWidth-1:0]     MinSectionLength = 12'd4;

   localparam logic [7:0] EitFirstId = 8'h4E;
   localparam logic [7:0] EitLastId  = 8'h6F;
   localparam logic [7:0] SdtActualId = 8'h42;
   localparam logic [7:0] SdtOtherId  = 8'h46;
   localparam logic [7:0] BatId       = 8'h4A;

   typedef enum logic [1:0] {
      CLASS_EVENT_INFO   = 2'd0,
      CLASS_SERVICE_DESC = 2'd1,
      CLASS_BOUQUET      = 2'd2,
      CLASS_OTHER        = 2'd3
   } table_class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_start;
   } req_beat_type;

   typedef struct packed {
      logic [7:0]              tbl_id;
      table_class_type         table_class;
      logic [BytePosWidth-1:0] section_bytes;
      logic                    crc_ok;
      logic                    malformed;
   } result_type;

   // Handshake state between the stages of the pipeline.
   typedef struct packed {
      logic advance;
   } stage_ctl_type;

   // One byte of CRC-32/MPEG-2, MSB first, not reflected.
   function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc,
                                                    input logic [7:0] b);
      logic [CrcWidth-1:0] c;
      c = crc ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         if (c[CrcWidth-1]) begin
            c = {c[CrcWidth-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[CrcWidth-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic table_class_type classify(input logic [7:0] tid);
      table_class_type cls;
      if (tid >= EitFirstId && tid <= EitLastId) begin
         cls = CLASS_EVENT_INFO;
      end else if (tid == SdtActualId || tid == SdtOtherId) begin
         cls = CLASS_SERVICE_DESC;
      end else if (tid == BatId) begin
         cls = CLASS_BOUQUET;
      end else begin
         cls = CLASS_OTHER;
      end
      return cls;
   endfunction

endpackage

// ===== hw/rtl/sicc_req_if.sv =====
// Input channel of the SI section deframer: one stream byte per beat.
// No dependencies.
interface sicc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_start;

   modport source (output valid, output data_byte, output buffer_start, input ready);
   modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

// ===== hw/rtl/sicc_rsp_if.sv =====
// Result channel of the SI section deframer: one finished section per beat.
// No dependencies.
interface sicc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tbl_id;
   logic [1:0]  table_class;
   logic [12:0] section_bytes;
   logic        crc_ok;
   logic        malformed;

   modport source (output valid, output tbl_id, output table_class,
                   output section_bytes, output crc_ok, output malformed, input ready);
   modport sink   (input valid, input tbl_id, input table_class,
                   input section_bytes, input crc_ok, input malformed, output ready);
endinterface

// ===== hw/rtl/sicc_in_stage.sv =====
// Input register of the SI section deframer: holds one accepted stream byte.
// Depends on sicc_pkg.
module sicc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  sicc_pkg::req_beat_type req_beat,
   input  logic                  advance,
   output logic                  req_ready,
   output logic                  in_valid,
   output sicc_pkg::req_beat_type in_beat
);
   import sicc_pkg::*;

   logic         valid_ff, valid_in;
   req_beat_type beat_ff;

   // The held byte leaves when the framer takes it, so a new one may enter the same cycle.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         beat_ff <= req_beat;
      end
   end

   assign in_valid = valid_ff;
   assign in_beat  = beat_ff;
endmodule

// ===== hw/rtl/sicc_framer.sv =====
// Section framing state and byte-wide CRC-32/MPEG-2 update of the SI deframer.
// Depends on sicc_pkg.
module sicc_framer (
   input  logic                   clock,
   input  logic                   reset,
   input  sicc_pkg::stage_ctl_type ctl,
   input  sicc_pkg::req_beat_type  in_beat,
   output logic                   result_hit,
   output sicc_pkg::result_type    result
);
   import sicc_pkg::*;

   logic [BytePosWidth-1:0] pos_ff, pos_in;
   logic [LenWidth-1:0]     len_ff, len_in;
   logic [7:0]              tid_ff, tid_in;
   logic [CrcWidth-1:0]     crc_ff, crc_in;

   logic [BytePosWidth-1:0] pos;
   logic [BytePosWidth-1:0] pos_plus;
   logic [BytePosWidth-1:0] total;
   logic [LenWidth-1:0]     len_cur;
   logic [7:0]              tid_cur;
   logic [CrcWidth-1:0]     crc_base;
   logic [CrcWidth-1:0]     crc_new;
   logic                    done;
   logic                    bad;

   always_comb begin
      pos      = in_beat.buffer_start ? '0 : pos_ff;
      pos_plus = pos + 13'd1;
      tid_cur  = tid_ff;
      len_cur  = len_ff;
      crc_base = crc_ff;
      if (pos == 13'd0) begin
         crc_base = CrcInit;
         tid_cur  = in_beat.data_byte;
         len_cur  = '0;
      end else if (pos == 13'd1) begin
         len_cur = {in_beat.data_byte[3:0], 8'h00};
      end else if (pos == 13'd2) begin
         len_cur = {len_ff[11:8], in_beat.data_byte};
      end
      crc_new = crc_byte(crc_base, in_beat.data_byte);
      total   = {1'b0, len_cur} + PrefixBytes;
      // A section of length zero ends on the second length byte.
      done    = (pos >= 13'd2) && (pos_plus >= total);
      bad     = len_cur < MinSectionLength;

      result.tbl_id        = tid_cur;
      result.table_class   = classify(tid_cur);
      result.section_bytes = total;
      result.crc_ok        = !bad && (crc_new == '0);
      result.malformed     = bad;
      result_hit           = ctl.advance && done;

      pos_in = pos_ff;
      len_in = len_ff;
      tid_in = tid_ff;
      crc_in = crc_ff;
      if (ctl.advance) begin
         pos_in = done ? '0 : pos_plus;
         len_in = len_cur;
         tid_in = tid_cur;
         crc_in = done ? CrcInit : crc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         len_ff <= '0;
         tid_ff <= '0;
         crc_ff <= CrcInit;
      end else begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         tid_ff <= tid_in;
         crc_ff <= crc_in;
      end
   end
endmodule

// ===== hw/rtl/sicc_out_stage.sv =====
// Result register of the SI section deframer, decoupling the result consumer.
// Depends on sicc_pkg.
module sicc_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sicc_pkg::result_type result,
   input  logic                rsp_ready,
   output logic                out_free,
   output logic                rsp_valid,
   output sicc_pkg::result_type rsp_result
);
   import sicc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;
endmodule

// ===== hw/rtl/si_section_crc_check_classify_unit.sv =====
// SI section deframer with CRC-32/MPEG-2 check and table classification. It takes one
// stream byte per beat and sustains one byte per cycle while the result register is free
// or being taken; a section's result is computed from its last byte in the input register
// and loaded into the result register as that byte advances; one beat leaves per finished
// section. The rate is set by the byte-wide CRC update and framing logic between the input
// register and the result register. buffer_start drops any partial section and takes
// its byte as a new table id; section lengths below four are reported as malformed with
// crc_ok low. Depends on sicc_pkg and the two channel interfaces.
module si_section_crc_check_classify_unit (
   input  logic       clock,
   input  logic       reset,
   sicc_req_if.sink   req_ch,
   sicc_rsp_if.source rsp_ch
);
   import sicc_pkg::*;

   req_beat_type  req_beat;
   req_beat_type  in_beat;
   stage_ctl_type ctl;
   result_type    result;
   result_type    rsp_result;
   logic          in_valid;
   logic          out_free;
   logic          result_hit;

   assign req_beat.data_byte    = req_ch.data_byte;
   assign req_beat.buffer_start = req_ch.buffer_start;

   assign ctl.advance  = in_valid && out_free;

   sicc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_beat  (req_beat),
      .advance   (ctl.advance),
      .req_ready (req_ch.ready),
      .in_valid  (in_valid),
      .in_beat   (in_beat)
   );

   sicc_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .in_beat    (in_beat),
      .result_hit (result_hit),
      .result     (result)
   );

   sicc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (result_hit),
      .result     (result),
      .rsp_ready  (rsp_ch.ready),
      .out_free   (out_free),
      .rsp_valid  (rsp_ch.valid),
      .rsp_result (rsp_result)
   );

   assign rsp_ch.tbl_id        = rsp_result.tbl_id;
   assign rsp_ch.table_class   = rsp_result.table_class;
   assign rsp_ch.section_bytes = rsp_result.section_bytes;
   assign rsp_ch.crc_ok        = rsp_result.crc_ok;
   assign rsp_ch.malformed     = rsp_result.malformed;
endmodule

// ===== hw/rtl/sicc_checker.sv =====
// Port-level checks of the SI section deframer, bound to the top level.
// Depends on sicc_pkg and si_section_crc_check_classify_unit.
module sicc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_tbl_id,
   input logic [1:0]  rsp_table_class,
   input logic [12:0] rsp_section_bytes,
   input logic        rsp_crc_ok,
   input logic        rsp_malformed
);
   import sicc_pkg::*;

   // A result beat stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_tbl_id) && $stable(rsp_section_bytes)
                                  && $stable(rsp_crc_ok) && $stable(rsp_malformed))
      else $error("result beat changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // A short section never reports a good CRC, and its size agrees with the flag.
   a_malformed_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_malformed == (rsp_section_bytes < 13'd7))
                    && !(rsp_malformed && rsp_crc_ok) && (rsp_section_bytes >= 13'd3))
      else $error("malformed flag inconsistent with section size or CRC");

   a_class_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_table_class == classify(rsp_tbl_id))
      else $error("table class does not match table id");
endmodule

bind si_section_crc_check_classify_unit sicc_checker u_sicc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_tbl_id        (rsp_ch.tbl_id),
   .rsp_table_class   (rsp_ch.table_class),
   .rsp_section_bytes (rsp_ch.section_bytes),
   .rsp_crc_ok        (rsp_ch.crc_ok),
   .rsp_malformed     (rsp_ch.malformed)
);
